### hw/rtl/sprite_line_render_collide_core_macros.svh
// Assertion macros for the sprite line renderer checker.
// Used by the checker file; no other dependencies.
`ifndef SPRITE_LINE_RENDER_COLLIDE_CORE_MACROS_SVH
`define SPRITE_LINE_RENDER_COLLIDE_CORE_MACROS_SVH

// same-cycle implication, reset aware
`define SLRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, reset aware
`define SLRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/slrc_pkg.sv
// Shared types and constants for the sprite line renderer.
// No dependencies.
`timescale 1ns / 1ps
package slrc_pkg;

  localparam logic [1:0] MODE_RENDER = 2'd0;
  localparam logic [1:0] MODE_PIXEL  = 2'd1;
  localparam logic [1:0] MODE_COLL   = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] REG_PPOS  = 2'd0;
  localparam logic [1:0] REG_MPOS  = 2'd1;
  localparam logic [1:0] REG_PSIZE = 2'd2;
  localparam logic [1:0] REG_MSIZE = 2'd3;

  localparam logic [9:0] POS_OFFSET = 10'h020;
  localparam logic [4:0] PLAYER_LAST_STEP = 5'd31;
  localparam logic [4:0] MISSILE_LAST_STEP = 5'd7;
  localparam logic [2:0] LAST_OBJ = 3'd7;

  typedef struct packed {
    logic       load;
    logic       clear_line;
    logic       clear_hits;
    logic       pix_rd;
    logic       draw_rd;
    logic       draw_wr;
    logic       out_load;
    logic [2:0] obj;
    logic [4:0] step;
  } cmd_t;

  typedef struct packed {
    logic drawable;
  } sts_t;

  // log2 of pixels per graphics bit: widths 1, 2, 1, 4
  function automatic logic [1:0] size_shift(logic [1:0] code);
    logic [1:0] r;
    case (code)
      2'd1:    r = 2'd1;
      2'd3:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/slrc_ctrl.sv
// Controller state machine: sequences render sweeps, reads and result handoff.
// Depends on slrc_pkg.
`timescale 1ns / 1ps
module slrc_ctrl import slrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DRAW_RD = 3'd1;
  localparam logic [2:0] ST_DRAW_WR = 3'd2;
  localparam logic [2:0] ST_PIX_RD  = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] obj_q, obj_d;
  logic [4:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       last_step;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign last_step   = obj_q[2] ? (step_q == MISSILE_LAST_STEP) : (step_q == PLAYER_LAST_STEP);

  always_comb begin
    state_d     = state_q;
    obj_d       = obj_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.obj   = obj_q;
    cmd_o.step  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          obj_d      = '0;
          step_d     = '0;
          unique case (mode_i)
            MODE_RENDER: begin
              cmd_o.clear_line = 1'b1;
              state_d          = ST_DRAW_RD;
            end
            MODE_PIXEL: state_d = ST_PIX_RD;
            MODE_COLL:  state_d = ST_DONE;
            MODE_CLEAR: begin
              cmd_o.clear_hits = 1'b1;
              state_d          = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_DRAW_RD, ST_DRAW_WR: begin
        if (state_q == ST_DRAW_RD && sts_i.drawable) begin
          cmd_o.draw_rd = 1'b1;
          state_d       = ST_DRAW_WR;
        end else begin
          cmd_o.draw_wr = (state_q == ST_DRAW_WR);
          state_d       = ST_DRAW_RD;
          if (last_step) begin
            step_d = '0;
            if (obj_q == LAST_OBJ) begin
              state_d = ST_DONE;
            end else begin
              obj_d = obj_q + 3'd1;
            end
          end else begin
            step_d = step_q + 5'd1;
          end
        end
      end
      ST_PIX_RD: begin
        cmd_o.pix_rd = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      obj_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      obj_q       <= obj_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hw/rtl/slrc_datapath.sv
// Datapath: config registers, line overlay memory, hit registers, result register.
// Depends on slrc_pkg.
`timescale 1ns / 1ps
module slrc_datapath import slrc_pkg::*; #(
  parameter int LINE_PIXELS = 192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  player0_bits_i,
  input  logic [7:0]  player1_bits_i,
  input  logic [7:0]  player2_bits_i,
  input  logic [7:0]  player3_bits_i,
  input  logic [7:0]  missile_bits_i,
  input  logic [7:0]  pixel_x_i,
  input  logic [2:0]  collision_sel_i,
  output logic [7:0]  read_data_o,
  input  cmd_t        cmd_i,
  output sts_t        sts_o
);

  localparam int AW = (LINE_PIXELS > 1) ? $clog2(LINE_PIXELS) : 1;

  logic [31:0] ppos_q, mpos_q;
  logic [7:0]  psize_q, msize_q;
  logic [1:0]  mode_q;
  logic [7:0]  pg_q [4];
  logic [7:0]  mb_q;
  logic [7:0]  px_q;
  logic [2:0]  sel_q;
  logic [3:0]  phits_q [4];
  logic [3:0]  mhits_q [4];
  logic [7:0]  mem_q [LINE_PIXELS];
  logic [LINE_PIXELS-1:0] valid_q;
  logic [7:0]  rdata_q;
  logic        rd_valid_q;
  logic [7:0]  out_q;

  logic [1:0]  n;
  logic        is_missile;
  logic [7:0]  pos;
  logic [1:0]  sh;
  logic [4:0]  b;
  logic        on;
  logic [9:0]  xs;
  logic [AW-1:0] xa, rd_addr;
  logic [7:0]  old_pix, new_pix;
  logic [3:0]  coll;
  logic [7:0]  pix_val;
  logic [7:0]  result;
  logic        wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_PPOS:  prdata = ppos_q;
      REG_MPOS:  prdata = mpos_q;
      REG_PSIZE: prdata = {24'd0, psize_q};
      REG_MSIZE: prdata = {24'd0, msize_q};
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    is_missile = cmd_i.obj[2];
    n          = is_missile ? ~cmd_i.obj[1:0] : cmd_i.obj[1:0];
    pos        = is_missile ? mpos_q[{n, 3'b000} +: 8] : ppos_q[{n, 3'b000} +: 8];
    sh         = size_shift(is_missile ? msize_q[{n, 1'b0} +: 2] : psize_q[{n, 1'b0} +: 2]);
    b          = cmd_i.step >> sh;
    if (is_missile) begin
      on = (b < 5'd2) && mb_q[{n, ~b[0]}];
    end else begin
      on = (b < 5'd8) && pg_q[n][3'd7 - b[2:0]];
    end
    xs       = {2'b00, pos} + {5'd0, cmd_i.step} - POS_OFFSET;
    xa       = xs[AW-1:0];
    sts_o.drawable = on && !xs[9] && (xs < 10'(LINE_PIXELS));
    rd_addr  = cmd_i.pix_rd ? px_q[AW-1:0] : xa;
    old_pix  = rd_valid_q ? rdata_q : 8'd0;
    new_pix  = is_missile ? (old_pix | (8'h10 << n)) : (old_pix | (8'h01 << n));
  end

  always_comb begin
    coll = '0;
    for (int m = 0; m < 4; m++) begin
      if (m < int'(sel_q[1:0])) begin
        coll[m] = phits_q[sel_q[1:0]][m];
      end else if (m > int'(sel_q[1:0])) begin
        coll[m] = phits_q[m][sel_q[1:0]];
      end
    end
    pix_val = (({1'b0, px_q} < 9'(LINE_PIXELS)) && rd_valid_q) ? rdata_q : 8'd0;
    case (mode_q)
      MODE_PIXEL: result = pix_val;
      MODE_COLL:  result = sel_q[2] ? {4'd0, mhits_q[sel_q[1:0]]} : {4'd0, coll};
      default:    result = 8'd0;
    endcase
  end

  assign read_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppos_q  <= 32'h20202020;
      mpos_q  <= 32'h20202020;
      psize_q <= 8'h55;
      msize_q <= 8'h55;
      valid_q <= '0;
      for (int i = 0; i < 4; i++) begin
        phits_q[i] <= '0;
        mhits_q[i] <= '0;
      end
    end else begin
      if (wr_en) begin
        unique case (paddr[3:2])
          REG_PPOS:  ppos_q  <= pwdata;
          REG_MPOS:  mpos_q  <= pwdata;
          REG_PSIZE: psize_q <= pwdata[7:0];
          REG_MSIZE: msize_q <= pwdata[7:0];
          default:   ppos_q  <= ppos_q;
        endcase
      end
      if (cmd_i.clear_line) begin
        valid_q <= '0;
      end else if (cmd_i.draw_wr) begin
        valid_q[xa] <= 1'b1;
      end
      if (cmd_i.clear_hits) begin
        for (int i = 0; i < 4; i++) begin
          phits_q[i] <= '0;
          mhits_q[i] <= '0;
        end
      end else if (cmd_i.draw_wr) begin
        if (is_missile) begin
          mhits_q[n] <= mhits_q[n] | old_pix[3:0];
        end else begin
          phits_q[n] <= phits_q[n] | new_pix[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_i;
      pg_q[0]  <= player0_bits_i;
      pg_q[1]  <= player1_bits_i;
      pg_q[2]  <= player2_bits_i;
      pg_q[3]  <= player3_bits_i;
      mb_q     <= missile_bits_i;
      px_q     <= pixel_x_i;
      sel_q    <= collision_sel_i;
    end
    if (cmd_i.pix_rd || cmd_i.draw_rd) begin
      rdata_q    <= mem_q[rd_addr];
      rd_valid_q <= valid_q[rd_addr];
    end
    if (cmd_i.draw_wr) begin
      mem_q[xa] <= new_pix;
    end
    if (cmd_i.out_load) begin
      out_q <= result;
    end
  end

endmodule

### hw/rtl/sprite_line_render_collide_core.sv
// Top level of the sprite line renderer with collision detection.
// Depends on slrc_pkg, slrc_ctrl and slrc_datapath.
//
// Usage: one request on the input channel (mode plus graphics, pixel index,
// collision select) yields exactly one result on the output channel
// (read_data). Both channels use valid/stall; a request is taken when
// in_valid_i is high and in_stall_o low. in_stall_o stays high while a
// request is in progress.
// Sequence: render scans 4*32 + 4*8 = 160 pixel slots in ST_DRAW_RD and
// visits ST_DRAW_WR as well for each drawn pixel, set by the single
// read-modify-write port of the overlay memory. Read pixel passes through
// ST_PIX_RD; read collision and clear collisions go straight to ST_DONE.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver still stalls when the next result is ready, the
// block holds it internally until the register frees.
// Reset: configuration returns to positions 0x20202020 and sizes 0x55, the
// overlay reads as zero through per-pixel valid flags, hit registers clear.
// No clearing pass is needed.
`timescale 1ns / 1ps
module sprite_line_render_collide_core import slrc_pkg::*; #(
  parameter int LINE_PIXELS = 192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  player0_bits_i,
  input  logic [7:0]  player1_bits_i,
  input  logic [7:0]  player2_bits_i,
  input  logic [7:0]  player3_bits_i,
  input  logic [7:0]  missile_bits_i,
  input  logic [7:0]  pixel_x_i,
  input  logic [2:0]  collision_sel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o
);

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  slrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  slrc_datapath #(.LINE_PIXELS(LINE_PIXELS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .mode_i          (mode_i),
    .player0_bits_i  (player0_bits_i),
    .player1_bits_i  (player1_bits_i),
    .player2_bits_i  (player2_bits_i),
    .player3_bits_i  (player3_bits_i),
    .missile_bits_i  (missile_bits_i),
    .pixel_x_i       (pixel_x_i),
    .collision_sel_i (collision_sel_i),
    .read_data_o     (read_data_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

### hw/rtl/slrc_checker.sv
// Port-level checker for the sprite line renderer, bound to the top level.
// Depends on sprite_line_render_collide_core_macros.svh.
`timescale 1ns / 1ps
`include "sprite_line_render_collide_core_macros.svh"
module slrc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o
);

  `SLRC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(read_data_o))
  `SLRC_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `SLRC_ASSERT_NOW(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind sprite_line_render_collide_core slrc_checker u_slrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o)
);
